@@ design/dat_pkg.sv @@
// ----------------------------------------------------------------------------
// Disc access time package
// Widths, cell counts, disc geometry and rate constants shared by the
// radius chain, the read divider chain and the top level.
// ----------------------------------------------------------------------------
package dat_pkg;

	localparam int OFF_W = 41;
	localparam int LEN_W = 40;
	localparam int RAD_W = 32;
	localparam int T_W = 52;
	localparam int LAYER_W = 33;
	localparam int R2_W = 53;
	localparam int SQ_REM_W = 34;
	localparam int EXC_W = 38;
	localparam int M_W = 56;
	localparam int P_W = 51;
	localparam int N_W = 101;
	localparam int NLOW_W = 55;
	localparam int Q_W = 55;

	localparam int FOLD_CELLS = 8;
	localparam int R2_CELLS = 64;
	localparam int SQRT_CELLS = 32;
	localparam int RAD_LAT = FOLD_CELLS + 2 + R2_CELLS + SQRT_CELLS;
	localparam int DIV_CELLS = Q_W;

	localparam logic [63:0] LAYER_BYTES = 64'h1_1824_0000;
	localparam logic [63:0] TWO_LAYER = LAYER_BYTES * 64'd2;
	localparam logic [63:0] NUM_BASE = LAYER_BYTES * 64'd576;
	localparam logic [63:0] NUM_SLOPE = 64'd2788;
	localparam logic [63:0] R2_DEN = LAYER_BYTES * 64'd1000000;

	localparam logic KIND_SEEK = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [T_W-1:0] TIME_MAX = {T_W{1'b1}};
	localparam logic [T_W-1:0] SEEK_SHORT_BASE = 52'd193273528;
	localparam logic [T_W-1:0] SEEK_LONG_BASE = 52'd365072220;
	localparam logic [RAD_W-1:0] SEEK_SHORT_MAX_D = 32'd4294967;

	localparam logic [41:0] INNER_SCALED = 42'd24 << 32;
	localparam logic [15:0] LEN_SCALE_LARGE = 16'd34000;
	localparam logic [15:0] LEN_SCALE_SMALL = 16'd14000;
	localparam logic [P_W-1:0] SIW_LARGE = 51'd118320 << 32;
	localparam logic [P_W-1:0] SIW_SMALL = 51'd29400 << 32;
	localparam logic [12:0] DV_LARGE = 13'd4930;
	localparam logic [12:0] DV_SMALL = 13'd1225;

	localparam logic [RAD_W-1:0] RADIUS_MIN = 32'd103079214;
	localparam logic [RAD_W-1:0] RADIUS_MAX = 32'd249108104;

	typedef struct packed {
		logic kind;
		logic large_set;
		logic [LEN_W-1:0] len;
	} dat_req_t;

	typedef struct packed {
		logic kind;
		logic [T_W-1:0] seek_t;
	} dat_side_t;

endpackage

@@ design/dat_radius.sv @@
// ----------------------------------------------------------------------------
// Disc access time radius chain
// Folds a byte offset onto the two layers, forms the squared radius by a
// row of restoring division cells and takes its root by a row of root cells.
// ----------------------------------------------------------------------------
module dat_radius (
	input logic clk,
	input logic [dat_pkg::OFF_W-1:0] offset,
	output logic [dat_pkg::RAD_W-1:0] radius
);
	import dat_pkg::*;

	logic [OFF_W-1:0] fold_q [FOLD_CELLS];
	logic [OFF_W-1:0] last_fold;
	logic [LAYER_W-1:0] flat_q;
	logic [R2_W-1:0] num_q;
	logic [R2_W-1:0] r2rem_q [R2_CELLS-1];
	logic [63:0] r2quo_q [R2_CELLS];
	logic [63:0] sqv_q [SQRT_CELLS-1];
	logic [SQ_REM_W-1:0] sqrem_q [SQRT_CELLS-1];
	logic [RAD_W-1:0] sqroot_q [SQRT_CELLS];

	for (genvar k = 0; k < FOLD_CELLS; k++) begin : g_fold
		localparam logic [OFF_W-1:0] STEP = OFF_W'(TWO_LAYER << (FOLD_CELLS - 1 - k));
		logic [OFF_W-1:0] src;
		if (k == 0) begin : g_first
			assign src = offset;
		end else begin : g_next
			assign src = fold_q[k-1];
		end
		always_ff @(posedge clk) begin
			fold_q[k] <= (src >= STEP) ? src - STEP : src;
		end
	end

	assign last_fold = fold_q[FOLD_CELLS-1];

	always_ff @(posedge clk) begin
		if (last_fold > OFF_W'(LAYER_BYTES)) begin
			flat_q <= LAYER_W'(OFF_W'(TWO_LAYER) - last_fold);
		end else begin
			flat_q <= LAYER_W'(last_fold);
		end
		num_q <= R2_W'(NUM_BASE) + R2_W'(flat_q) * R2_W'(NUM_SLOPE);
	end

	for (genvar k = 0; k < R2_CELLS; k++) begin : g_r2
		logic [R2_W-1:0] src_rem;
		logic [63:0] src_quo;
		logic [R2_W:0] sh;
		logic ge;
		if (k == 0) begin : g_first
			assign src_rem = num_q;
			assign src_quo = '0;
		end else begin : g_next
			assign src_rem = r2rem_q[k-1];
			assign src_quo = r2quo_q[k-1];
		end
		assign sh = {src_rem, 1'b0};
		assign ge = sh >= (R2_W + 1)'(R2_DEN);
		always_ff @(posedge clk) begin
			r2quo_q[k] <= {src_quo[62:0], ge};
		end
		if (k < R2_CELLS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				r2rem_q[k] <= ge ? R2_W'(sh - (R2_W + 1)'(R2_DEN)) : sh[R2_W-1:0];
			end
		end
	end

	for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
		logic [63:0] src_v;
		logic [SQ_REM_W-1:0] src_rem;
		logic [RAD_W-1:0] src_root;
		logic [SQ_REM_W:0] bring;
		logic [SQ_REM_W:0] trial;
		logic ge;
		if (k == 0) begin : g_first
			assign src_v = r2quo_q[R2_CELLS-1];
			assign src_rem = '0;
			assign src_root = '0;
		end else begin : g_next
			assign src_v = sqv_q[k-1];
			assign src_rem = sqrem_q[k-1];
			assign src_root = sqroot_q[k-1];
		end
		assign bring = {src_rem[SQ_REM_W-2:0], src_v[63:62]};
		assign trial = (SQ_REM_W + 1)'({src_root, 2'b01});
		assign ge = bring >= trial;
		always_ff @(posedge clk) begin
			sqroot_q[k] <= {src_root[RAD_W-2:0], ge};
		end
		if (k < SQRT_CELLS - 1) begin : g_pass
			always_ff @(posedge clk) begin
				sqrem_q[k] <= ge ? SQ_REM_W'(bring - trial) : SQ_REM_W'(bring);
				sqv_q[k] <= {src_v[61:0], 2'b00};
			end
		end
	end

	assign radius = sqroot_q[SQRT_CELLS-1];

endmodule

@@ design/dat_qdiv.sv @@
// ----------------------------------------------------------------------------
// Disc access time read divider
// A row of restoring division cells, one quotient bit per cell, that
// divides the scaled read length by the speed term.
// ----------------------------------------------------------------------------
module dat_qdiv (
	input logic clk,
	input logic [dat_pkg::P_W-1:0] divisor,
	input logic [dat_pkg::P_W-1:0] rem0,
	input logic [dat_pkg::NLOW_W-1:0] nlow,
	input dat_pkg::dat_side_t side_in,
	output logic [dat_pkg::Q_W-1:0] quo,
	output dat_pkg::dat_side_t side_out
);
	import dat_pkg::*;

	logic [P_W-1:0] rem_q [DIV_CELLS-1];
	logic [P_W-1:0] p_q [DIV_CELLS-1];
	logic [NLOW_W-1:0] nlow_q [DIV_CELLS-1];
	logic [Q_W-1:0] quo_q [DIV_CELLS];
	dat_side_t side_q [DIV_CELLS];

	for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
		logic [P_W-1:0] src_rem;
		logic [P_W-1:0] src_p;
		logic [NLOW_W-1:0] src_nlow;
		logic [Q_W-1:0] src_quo;
		dat_side_t src_side;
		logic [P_W:0] sh;
		logic ge;
		if (k == 0) begin : g_first
			assign src_rem = rem0;
			assign src_p = divisor;
			assign src_nlow = nlow;
			assign src_quo = '0;
			assign src_side = side_in;
		end else begin : g_next
			assign src_rem = rem_q[k-1];
			assign src_p = p_q[k-1];
			assign src_nlow = nlow_q[k-1];
			assign src_quo = quo_q[k-1];
			assign src_side = side_q[k-1];
		end
		assign sh = {src_rem, src_nlow[NLOW_W-1]};
		assign ge = sh >= {1'b0, src_p};
		always_ff @(posedge clk) begin
			quo_q[k] <= {src_quo[Q_W-2:0], ge};
			side_q[k] <= src_side;
		end
		if (k < DIV_CELLS - 1) begin : g_pass
			always_ff @(posedge clk) begin
				rem_q[k] <= ge ? P_W'(sh - {1'b0, src_p}) : P_W'(sh);
				p_q[k] <= src_p;
				nlow_q[k] <= {src_nlow[NLOW_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q[DIV_CELLS-1];
	assign side_out = side_q[DIV_CELLS-1];

endmodule

@@ design/disc_access_time_unit.sv @@
// ----------------------------------------------------------------------------
// Disc access time unit
// Gives the seek time between two offsets or the read time of a span.
//
//   channel   signals                                   direction
//   request   start, busy, kind, offset_a, offset_b,    in (busy out)
//             large_disc
//   result    done, time_q32                            out
//
// A request is taken on every cycle that start is high; busy stays low.
// Each result appears with done after its request has passed the input
// register, radius chain, stage registers, divider and output register.
// Reset clears only the valid line; results cannot be held off, so
// nothing in the block ever stalls.
// ----------------------------------------------------------------------------
module disc_access_time_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic kind,
	input logic [39:0] offset_a,
	input logic [39:0] offset_b,
	input logic large_disc,
	output logic done,
	output logic [51:0] time_q32
);
	import dat_pkg::*;

	localparam int VLD_N = RAD_LAT + DIV_CELLS + 5;

	logic [VLD_N-1:0] vld_q;
	logic [OFF_W-1:0] off_a_s1;
	logic [OFF_W-1:0] off_b_s1;
	dat_req_t req_s1;
	dat_req_t req_q [RAD_LAT];
	logic [RAD_W-1:0] rad_a;
	logic [RAD_W-1:0] rad_b;
	dat_req_t req_end;
	logic [41:0] scaled;
	logic [RAD_W-1:0] d_s2;
	logic [EXC_W-1:0] exc_s2;
	logic [M_W-1:0] m_s2;
	logic kind_s2;
	logic large_s2;
	logic [P_W-1:0] p_s3;
	logic [T_W-1:0] seekt_s3;
	logic [M_W-1:0] m_s3;
	logic kind_s3;
	logic [N_W-1:0] n_sum;
	logic [P_W-1:0] p_s4;
	logic [P_W-1:0] rem0_s4;
	logic [NLOW_W-1:0] nlow_s4;
	dat_side_t side_s4;
	logic [Q_W-1:0] quo;
	dat_side_t side_o;
	logic [T_W-1:0] read_t;
	logic [T_W-1:0] time_q;
	logic kind_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[VLD_N-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		if (kind == KIND_READ) begin
			off_a_s1 <= {1'b0, offset_a} + {2'b00, offset_b[39:1]};
		end else begin
			off_a_s1 <= {1'b0, offset_a};
		end
		off_b_s1 <= {1'b0, offset_b};
		req_s1 <= '{kind: kind, large_set: large_disc, len: offset_b};
	end

	dat_radius u_rad_a (
		.clk(clk),
		.offset(off_a_s1),
		.radius(rad_a)
	);

	dat_radius u_rad_b (
		.clk(clk),
		.offset(off_b_s1),
		.radius(rad_b)
	);

	for (genvar k = 0; k < RAD_LAT; k++) begin : g_req
		always_ff @(posedge clk) begin
			req_q[k] <= (k == 0) ? req_s1 : req_q[(k == 0) ? 0 : k - 1];
		end
	end

	assign req_end = req_q[RAD_LAT-1];
	assign scaled = 42'(rad_a) * 42'd1000;

	always_ff @(posedge clk) begin
		d_s2 <= (rad_a > rad_b) ? rad_a - rad_b : rad_b - rad_a;
		exc_s2 <= (scaled > INNER_SCALED) ? EXC_W'(scaled - INNER_SCALED) : '0;
		m_s2 <= M_W'(req_end.len)
			* M_W'(req_end.large_set ? LEN_SCALE_LARGE : LEN_SCALE_SMALL);
		kind_s2 <= req_end.kind;
		large_s2 <= req_end.large_set;
	end

	always_ff @(posedge clk) begin
		p_s3 <= (large_s2 ? SIW_LARGE : SIW_SMALL)
			+ P_W'(exc_s2) * P_W'(large_s2 ? DV_LARGE : DV_SMALL);
		if (d_s2 <= SEEK_SHORT_MAX_D) begin
			seekt_s3 <= T_W'(d_s2) * T_W'(50) + SEEK_SHORT_BASE;
		end else begin
			seekt_s3 <= (T_W'(d_s2) << 2) + ((T_W'(d_s2) + T_W'(1)) >> 1) + SEEK_LONG_BASE;
		end
		m_s3 <= m_s2;
		kind_s3 <= kind_s2;
	end

	assign n_sum = N_W'({m_s3, 44'b0}) + N_W'(p_s3 >> 1);

	always_ff @(posedge clk) begin
		p_s4 <= p_s3;
		rem0_s4 <= P_W'(n_sum[N_W-1:NLOW_W]);
		nlow_s4 <= n_sum[NLOW_W-1:0];
		side_s4 <= '{kind: kind_s3, seek_t: seekt_s3};
	end

	dat_qdiv u_qdiv (
		.clk(clk),
		.divisor(p_s4),
		.rem0(rem0_s4),
		.nlow(nlow_s4),
		.side_in(side_s4),
		.quo(quo),
		.side_out(side_o)
	);

	assign read_t = (quo[Q_W-1:T_W] != '0) ? TIME_MAX : quo[T_W-1:0];

	always_ff @(posedge clk) begin
		time_q <= (side_o.kind == KIND_READ) ? read_t : side_o.seek_t;
		kind_q <= side_o.kind;
	end

	assign done = vld_q[VLD_N-1];
	assign time_q32 = time_q;

	a_radius_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[RAD_LAT] |-> (rad_a >= RADIUS_MIN && rad_a <= RADIUS_MAX
			&& rad_b >= RADIUS_MIN && rad_b <= RADIUS_MAX))
		else $error("head radius outside the disc");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[RAD_LAT+3] |-> rem0_s4 < p_s4)
		else $error("divider partial remainder not below the divisor");

	a_seek_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kind_q == KIND_SEEK) |-> time_q32 >= SEEK_SHORT_BASE)
		else $error("seek time below the settle time");

endmodule

@@ sim/disc_access_time_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Disc access time unit testbench
// Drives seek and read requests into the unit, with random gaps between
// them, and predicts each time from the disc geometry in wide fixed-point
// arithmetic. Every result word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module disc_access_time_unit_tb;
	import dat_pkg::*;

	typedef struct {
		logic kind;
		logic [39:0] off_a;
		logic [39:0] off_b;
		logic large_set;
	} access_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic kind = 1'b0;
	logic [39:0] offset_a = '0;
	logic [39:0] offset_b = '0;
	logic large_disc = 1'b0;
	logic done;
	logic [51:0] time_q32;

	access_req_t req_q[$];
	logic [51:0] time_exp_q[$];
	int mismatches = 0;
	int gap = 0;
	int idle_cycles = 0;
	int n_random = 1650;

	disc_access_time_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.offset_a(offset_a), .offset_b(offset_b), .large_disc(large_disc),
		.done(done), .time_q32(time_q32)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] head_radius(logic [63:0] off);
		logic [63:0] f;
		logic [127:0] num;
		f = off % TWO_LAYER;
		if (f > LAYER_BYTES) f = TWO_LAYER - f;
		num = 128'(NUM_BASE + NUM_SLOPE * f) << 64;
		return isqrt(64'(num / 128'(R2_DEN)));
	endfunction

	function automatic logic [51:0] access_time(access_req_t r);
		logic [63:0] r1, r2, d, w, si, dv, rad, sc, exc, p;
		logic [127:0] n, q;
		if (r.kind == KIND_SEEK) begin
			r1 = head_radius(64'(r.off_a));
			r2 = head_radius(64'(r.off_b));
			d = r1 > r2 ? r1 - r2 : r2 - r1;
			if (d * 1000 < (64'd1 << 32))
				return 52'((d * 50000 + (64'd45 << 32) + 500) / 1000);
			return 52'((d * 9000 + (64'd170 << 32) + 1000) / 2000);
		end
		w = r.large_set ? 34 : 14;
		si = r.large_set ? 3480 : 2100;
		dv = r.large_set ? 4930 : 1225;
		rad = head_radius(64'(r.off_a) + 64'(r.off_b >> 1));
		sc = rad * 1000;
		exc = sc > (64'd24 << 32) ? sc - (64'd24 << 32) : 0;
		p = ((si * w) << 32) + exc * dv;
		n = (128'(64'(r.off_b) * (1000 * w)) << 44) + 128'(p >> 1);
		q = n / 128'(p);
		return q > 128'(TIME_MAX) ? TIME_MAX : 52'(q);
	endfunction

	function automatic logic [39:0] rand_off();
		case ($urandom_range(0, 4))
			0: return {8'($urandom_range(0, 255)), $urandom()};
			1: return 40'($urandom_range(0, 33)) * 40'(LAYER_BYTES[39:0]) / 16
				+ 40'($urandom_range(0, 2000)) - 40'd1000;
			2: return 40'($urandom_range(0, 100000));
			default: return 40'({$urandom(), $urandom()});
		endcase
	endfunction

	// Driver: one word per acceptance, with random gaps until the closing stretch.
	always @(posedge clk or negedge arst_n) begin
		logic go;
		access_req_t it;
		if (!arst_n) begin
			start <= 1'b0;
			gap = 0;
		end else begin
			go = start && busy;
			if (!go) begin
				if (gap > 0) begin
					gap--;
				end else if (req_q.size() > 0) begin
					it = req_q.pop_front();
					kind <= it.kind;
					offset_a <= it.off_a;
					offset_b <= it.off_b;
					large_disc <= it.large_set;
					go = 1'b1;
					if (req_q.size() > 200 && $urandom_range(0, 3) == 0)
						gap = $urandom_range(1, 15);
				end
			end
			start <= go;
		end
	end

	// Monitor: predicts on acceptance and checks each result word.
	always @(posedge clk) begin
		access_req_t r;
		logic [51:0] exp_t;
		if (arst_n) begin
			if (start && !busy) begin
				r.kind = kind;
				r.off_a = offset_a;
				r.off_b = offset_b;
				r.large_set = large_disc;
				time_exp_q.push_back(access_time(r));
			end
			if (done) begin
				if (time_exp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word: time_q32=%h", time_q32);
				end else begin
					exp_t = time_exp_q.pop_front();
					if (exp_t !== time_q32) begin
						mismatches++;
						if (mismatches <= 10)
							$display("time_q32 mismatch: expected %h, actual %h", exp_t,
								time_q32);
					end
				end
			end
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= 3000) begin
				$display("disc_access_time_unit_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic add_req(logic k, logic [39:0] a, logic [39:0] b, logic l);
		access_req_t r;
		r.kind = k;
		r.off_a = a;
		r.off_b = b;
		r.large_set = l;
		req_q.push_back(r);
	endtask

	initial begin
		logic [39:0] lay, a;
		lay = LAYER_BYTES[39:0];
		add_req(KIND_SEEK, 40'd0, 40'd0, 1'b0);
		add_req(KIND_SEEK, 40'd0, '1, 1'b1);
		add_req(KIND_SEEK, lay, 40'd0, 1'b0);
		add_req(KIND_SEEK, lay - 1, lay + 1, 1'b1);
		add_req(KIND_SEEK, 2 * lay, 40'd0, 1'b0);
		add_req(KIND_SEEK, 40'd1000, 40'd40000000, 1'b0);
		add_req(KIND_SEEK, 40'd1000, 40'd400000000, 1'b0);
		add_req(KIND_SEEK, '1, 40'h55_5555_5555, 1'b0);
		add_req(KIND_READ, 40'd0, 40'd0, 1'b0);
		add_req(KIND_READ, '1, 40'd0, 1'b1);
		add_req(KIND_READ, 40'd0, 40'd1, 1'b1);
		add_req(KIND_READ, '1, '1, 1'b0);
		add_req(KIND_READ, '1, '1, 1'b1);
		add_req(KIND_READ, 40'd0, '1, 1'b0);
		add_req(KIND_READ, lay, 40'd2048, 1'b1);
		add_req(KIND_READ, lay, 40'd2048, 1'b0);
		add_req(KIND_READ, 40'd0, 40'd32768, 1'b0);
		add_req(KIND_READ, 40'd0, 40'd32768, 1'b1);
		add_req(KIND_READ, lay - 1024, 40'd2048, 1'b1);
		add_req(KIND_READ, 40'hAA_AAAA_AAAA, 40'h55_5555_5555, 1'b1);
		for (int i = 0; i < n_random; i++) begin
			a = rand_off();
			if ($urandom_range(0, 1))
				add_req(KIND_SEEK, a, rand_off(), 1'($urandom()));
			else if ($urandom_range(0, 3) == 0)
				add_req(KIND_READ, a, rand_off(), 1'($urandom()));
			else
				add_req(KIND_READ, a, 40'($urandom_range(0, 1 << 20)), 1'($urandom()));
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (req_q.size() == 0 && !start);
		@(posedge clk);
		wait (time_exp_q.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && time_exp_q.size() == 0) begin
			$display("disc_access_time_unit_tb: PASS");
		end else begin
			$display("disc_access_time_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
